FILE: hdl/lbmq_pkg.sv
package lbmq_pkg;

  localparam int unsigned QueueDepthDefault = 8;
  localparam logic [7:0]  TickPeriodReset   = 8'd10;

  typedef enum logic [0:0] {
    FUNC_TICK = 1'b0,
    FUNC_PUSH = 1'b1
  } func_e;

  // static part of a queued message
  typedef struct packed {
    logic [14:0]        half_period;
    logic signed [15:0] blinks;
    logic [14:0]        gap;
  } msg_t;

endpackage

FILE: hdl/led_blink_message_queue.sv
// LED blink-code sequencer with a queue of up to QUEUE_DEPTH messages.
// Input channel (in_valid_i/in_ready_o): func_i selects a timer tick or a push
// of a message (half_period_i, blink_count_i, gap_after_i). Every transfer
// yields exactly one result on the output channel (out_valid_o/out_ready_i):
// the LED level, the queue fill and a flag for a push refused on a full queue.
// Configuration: one write channel (cfg_valid_i/cfg_ready_o) loads the tick
// period in ms; it is always ready and should be written only while idle.
// The result of a transfer is presented in the next cycle. Throughput is
// one item per cycle while the receiver takes results.
// The head message lives in registers; the rest sit in a RAM whose
// registered read port always prefetches the slot after the head, so a pop
// reloads the head in the same cycle.
// When the receiver stalls, the pending result holds and in_ready_o drops
// until it is taken. Reset empties the queue, clears any gap, drives the LED
// low and sets the tick period to 10 ms.
module led_blink_message_queue import lbmq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [7:0]         cfg_tick_period_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               func_i,
  input  logic [14:0]        half_period_i,
  input  logic signed [15:0] blink_count_i,
  input  logic [14:0]        gap_after_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               led_on_o,
  output logic [3:0]         queued_o,
  output logic               push_dropped_o
);

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  function automatic logic [PtrW-1:0] inc_ptr(input logic [PtrW-1:0] p);
    inc_ptr = (p == PtrW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  logic [7:0]         tick_q;
  logic [PtrW-1:0]    head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0]    count_q, count_d;
  logic signed [16:0] gap_q, gap_d;
  logic               led_q, led_d;
  logic               ov_q, ov_d;
  logic               drop_q, drop_d;

  // head message
  logic [14:0]        h_period_q, h_period_d;
  logic signed [16:0] h_time_q, h_time_d;
  logic signed [15:0] h_blinks_q, h_blinks_d;
  logic [14:0]        h_gap_q, h_gap_d;
  logic               h_level_q, h_level_d;

  logic               accept;
  logic               ram_we;
  logic [PtrW-1:0]    ram_raddr;
  msg_t               push_msg, next_msg;
  logic signed [16:0] tick_s;
  logic signed [15:0] blinks_dec;

  assign accept      = in_valid_i & in_ready_o;
  assign in_ready_o  = ~ov_q | out_ready_i;
  assign cfg_ready_o = 1'b1;
  assign tick_s      = signed'({9'd0, tick_q});
  assign blinks_dec  = h_blinks_q - 16'sd1;

  assign push_msg.half_period = half_period_i;
  assign push_msg.blinks      = blink_count_i;
  assign push_msg.gap         = gap_after_i;

  lbmq_ram #(
    .Width($bits(msg_t)),
    .Depth(QUEUE_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(tail_q),
    .wdata_i(push_msg),
    .raddr_i(ram_raddr),
    .rdata_o(next_msg)
  );

  always_comb begin
    logic do_pop;
    do_pop     = 1'b0;
    head_d     = head_q;
    tail_d     = tail_q;
    count_d    = count_q;
    gap_d      = gap_q;
    led_d      = led_q;
    drop_d     = drop_q;
    h_period_d = h_period_q;
    h_time_d   = h_time_q;
    h_blinks_d = h_blinks_q;
    h_gap_d    = h_gap_q;
    h_level_d  = h_level_q;
    ram_we     = 1'b0;
    ram_raddr  = inc_ptr(head_q);
    if (accept) begin
      drop_d = 1'b0;
      case (func_e'(func_i))
        FUNC_PUSH: begin
          if (count_q == CntW'(QUEUE_DEPTH)) begin
            drop_d = 1'b1;
          end else begin
            ram_we  = 1'b1;
            tail_d  = inc_ptr(tail_q);
            count_d = count_q + 1'b1;
            if (count_q == '0) begin
              h_period_d = half_period_i;
              h_time_d   = signed'({2'b00, half_period_i});
              h_blinks_d = blink_count_i;
              h_gap_d    = gap_after_i;
              h_level_d  = 1'b1;
            end
          end
        end
        FUNC_TICK: begin
          if (gap_q > 17'sd0) begin
            gap_d = gap_q - tick_s;
          end else if (count_q != '0) begin
            led_d = h_level_q;
            if (h_time_q > 17'sd0) begin
              h_time_d = h_time_q - tick_s;
            end else begin
              h_time_d  = signed'({2'b00, h_period_q});
              h_level_d = ~h_level_q;
              if (!h_level_q) begin
                // back to high: one blink done
                if (h_blinks_q < 16'sd0) begin
                  do_pop = (count_q > CntW'(1));
                end else begin
                  h_blinks_d = blinks_dec;
                  do_pop     = (blinks_dec <= 16'sd0);
                end
              end
            end
          end
        end
        default: begin
        end
      endcase
      if (do_pop) begin
        gap_d      = signed'({2'b00, h_gap_q});
        head_d     = inc_ptr(head_q);
        count_d    = count_q - 1'b1;
        ram_raddr  = inc_ptr(inc_ptr(head_q));
        h_period_d = next_msg.half_period;
        h_time_d   = signed'({2'b00, next_msg.half_period});
        h_blinks_d = next_msg.blinks;
        h_gap_d    = next_msg.gap;
        h_level_d  = 1'b1;
      end
    end
  end

  always_comb begin
    ov_d = ov_q;
    if (accept) begin
      ov_d = 1'b1;
    end else if (out_ready_i) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q  <= TickPeriodReset;
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      gap_q   <= '0;
      led_q   <= 1'b0;
      ov_q    <= 1'b0;
      drop_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        tick_q <= cfg_tick_period_i;
      end
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      gap_q   <= gap_d;
      led_q   <= led_d;
      ov_q    <= ov_d;
      drop_q  <= drop_d;
    end
  end

  always_ff @(posedge clk_i) begin
    h_period_q <= h_period_d;
    h_time_q   <= h_time_d;
    h_blinks_q <= h_blinks_d;
    h_gap_q    <= h_gap_d;
    h_level_q  <= h_level_d;
  end

  assign out_valid_o    = ov_q;
  assign led_on_o       = led_q;
  assign queued_o       = 4'(count_q);
  assign push_dropped_o = drop_q;

endmodule

FILE: hdl/lbmq_ram.sv
module lbmq_ram import lbmq_pkg::*; #(
  parameter int unsigned Width = $bits(msg_t),
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // write-first on a same-address collision
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
